FILE: hdl/gsve_pkg.sv
`timescale 1ns / 1ps

package gsve_pkg;

  localparam int CFG_W = 14;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SOURCE = 1'b1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [13:0] GRAIN_LENGTH_RST = 14'd1920;
  localparam logic        RIGHT_SOURCE_RST = 1'b1;
  localparam int          MIN_GRAIN_LEN    = 16;
  localparam int          OUT_MAX          = 524287;
  localparam int          OUT_MIN          = -524288;
  localparam int          WIN_BIAS         = 65538;
  localparam int          WIN_MAX          = 32768;
  localparam int          Q16_ONE          = 65536;

  typedef struct packed {
    logic               op;
    logic [15:0]        sample_addr;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic [31:0]        target_pos;
    logic signed [23:0] speed;
    logic [15:0]        level;
    logic               active;
    logic               prime;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] out_left;
    logic signed [19:0] out_right;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SP_MUL,
    ST_SP_POS,
    ST_SP_SCAN,
    ST_SP_WR,
    ST_G_CHK,
    ST_G_RD1,
    ST_G_DIV,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_DONE
  } state_t;

  // quarter-wave cosine, Q16, for u = 0..256
  typedef logic [256:0][18:0] qcos_tab_t;

  function automatic qcos_tab_t build_qcos_tab();
    qcos_tab_t t;
    longint    s;
    longint    r;
    for (int u = 0; u <= 256; u++) begin
      s = longint'(u) * longint'(u);
      r = 2;
      r = 60 - ((s * r) >>> 16);
      r = 1367 - ((s * r) >>> 16);
      r = 16624 - ((s * r) >>> 16);
      r = 80852 - ((s * r) >>> 16);
      t[u] = 19'(65536 - ((s * r) >>> 16));
    end
    return t;
  endfunction

  localparam qcos_tab_t QCOS_TAB = build_qcos_tab();

endpackage

FILE: hdl/granular_scrub_voice_engine_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                          Beat
// in        in_valid  in_ready  in_data    one write or render request
// out       out_valid out_ready out_data   one stereo result per render
// cfg       cfg_we cfg_index cfg_wdata     one register write, no wait
// A write does not stall the input. A render runs through every grain slot,
// plus a slot scan for each grain spawned, up to four on a prime.
// The shared multiplier and the 11-step window divider set its length.
// rst_n is synchronous; it clears the grains, hop counter and prime flag.
// A finished result waits in the output register; a new request is taken meanwhile.
module granular_scrub_voice_engine_unit #(
  parameter int MAX_GRAINS    = 8,
  parameter int MAX_GRAIN_LEN = 8192,
  parameter int STORE_DEPTH   = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gsve_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gsve_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [gsve_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gsve_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int LW   = $clog2(MAX_GRAIN_LEN + 1);
  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int GIW  = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
  localparam int ACCW = 48 + $clog2(MAX_GRAINS) + 1;
  localparam int MA   = ACCW - 16;
  localparam int PW   = MA + 25;
  localparam int NW   = LW + 11;
  localparam int DIV_LAST = 10;
  localparam logic [GIW-1:0] G_LAST = GIW'(MAX_GRAINS - 1);
  localparam logic signed [PW-1:0] SAT_HI = PW'(gsve_pkg::OUT_MAX);
  localparam logic signed [PW-1:0] SAT_LO = PW'(gsve_pkg::OUT_MIN);

  gsve_pkg::state_t state_r, state_nxt;

  logic [13:0] grain_length_r;
  logic        right_source_r;

  logic [15:0] store_left_r  [STORE_DEPTH];
  logic [15:0] store_right_r [STORE_DEPTH];
  logic [15:0] rd_l_r, rd_r_r;
  logic [AW-1:0] rd_addr;

  logic [39:0]     grain_pos_r  [MAX_GRAINS];
  logic [LW-1:0]   grain_age_r  [MAX_GRAINS];
  logic [LW-1:0]   grain_span_r [MAX_GRAINS];
  logic [MAX_GRAINS-1:0] live_r, live_nxt;

  logic [LW-1:0] hop_count_r, hop_count_nxt;
  logic          pp_r, pp_nxt;
  logic          out_valid_r, out_valid_nxt;
  gsve_pkg::out_item_t out_data_r, out_data_nxt;

  logic [GIW-1:0] g_r, g_nxt;
  logic [GIW-1:0] slot_r, slot_nxt;
  logic [1:0]     k_r, k_nxt;
  logic           prime_mode_r, prime_mode_nxt;
  logic           have_r, have_nxt;
  logic [LW-1:0]  oldest_r, oldest_nxt;
  logic [LW-1:0]  off_r, off_nxt;
  logic [39:0]    spawn_pos_r, spawn_pos_nxt;
  logic [LW-1:0]  spawn_age_r, spawn_age_nxt;
  logic [31:0]    target_r, target_nxt;
  logic signed [23:0] speed_r, speed_nxt;
  logic [15:0]    level_r, level_nxt;

  logic [3:0]     dcnt_r, dcnt_nxt;
  logic [LW-1:0]  rem_r, rem_nxt;
  logic [10:0]    num_r, num_nxt;
  logic [10:0]    q_r, q_nxt;
  logic [AW-1:0]  i1_addr_r, i1_addr_nxt;
  logic           v0_r, v0_nxt;
  logic           v1_r, v1_nxt;
  logic [15:0]    f_r, f_nxt;
  logic signed [15:0] s0_l_r, s0_l_nxt, s0_r_r, s0_r_nxt;
  logic [15:0]    w_r, w_nxt;
  logic signed [32:0] lin_l_r, lin_l_nxt, lin_r_r, lin_r_nxt;
  logic signed [ACCW-1:0] acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic signed [19:0] res_l_r, res_l_nxt, res_r_r, res_r_nxt;

  logic signed [MA-1:0] mul_a;
  logic signed [24:0]   mul_b;
  logic signed [PW-1:0] p_r;

  logic gsp_we, gup_we;
  logic in_fire, wr_fire;

  logic [LW-1:0] len_w, hop_w, hop3_w;
  logic [39:0]   cur_pos;
  logic [LW-1:0] cur_age, cur_span, d_w;
  logic [NW-1:0] div_n;
  logic signed [23:0] i_now;
  logic signed [24:0] i1_now;
  logic [LW+1:0] div_diff;
  logic [8:0]    win_u;
  logic signed [18:0] win_c;
  logic signed [20:0] win_raw;
  logic [15:0]   win_w;
  logic signed [15:0] s1_l, s1_r;
  logic [24:0]   f_inv;

  function automatic logic signed [19:0] sat20(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    sh = p >>> 31;
    if (sh > SAT_HI) begin
      return 20'(gsve_pkg::OUT_MAX);
    end else if (sh < SAT_LO) begin
      return 20'(gsve_pkg::OUT_MIN);
    end
    return 20'(sh);
  endfunction

  assign in_ready  = (state_r == gsve_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign wr_fire   = in_fire && (in_data.op == gsve_pkg::OP_WRITE)
                     && (32'(in_data.sample_addr) < STORE_DEPTH);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective length and hop
  always_comb begin
    if (grain_length_r < 14'(gsve_pkg::MIN_GRAIN_LEN)) begin
      len_w = LW'(gsve_pkg::MIN_GRAIN_LEN);
    end else if (32'(grain_length_r) > MAX_GRAIN_LEN) begin
      len_w = LW'(MAX_GRAIN_LEN);
    end else begin
      len_w = LW'(grain_length_r);
    end
    hop_w  = len_w >> 2;
    hop3_w = LW'({1'b0, hop_w} + {hop_w, 1'b0});
  end

  // current grain view and window divider setup
  always_comb begin
    cur_pos  = grain_pos_r[g_r];
    cur_age  = grain_age_r[g_r];
    cur_span = grain_span_r[g_r];
    d_w      = (cur_span > LW'(1)) ? cur_span - LW'(1) : LW'(1);
    div_n    = NW'({cur_age, 10'b0}) + NW'(d_w >> 1);
    i_now    = cur_pos[39:16];
    i1_now   = {i_now[23], i_now} + 25'sd1;
    div_diff = {1'b0, rem_r, num_r[10]} - {2'b0, d_w};
    rd_addr  = (state_r == gsve_pkg::ST_G_CHK) ? AW'(i_now) : i1_addr_r;
  end

  // Hann window lookup
  always_comb begin
    win_u   = q_r[8] ? (9'd256 - {1'b0, q_r[7:0]}) : {1'b0, q_r[7:0]};
    win_c   = $signed(gsve_pkg::QCOS_TAB[win_u]);
    win_raw = (q_r[9] ^ q_r[8]) ? 21'(gsve_pkg::WIN_BIAS) + 21'(win_c)
                                : 21'(gsve_pkg::WIN_BIAS) - 21'(win_c);
    if (win_raw < 0) begin
      win_w = '0;
    end else if ((win_raw >>> 2) > 21'(gsve_pkg::WIN_MAX)) begin
      win_w = 16'(gsve_pkg::WIN_MAX);
    end else begin
      win_w = 16'(win_raw >>> 2);
    end
  end

  always_comb begin
    s1_l  = v1_r ? $signed(rd_l_r) : 16'sd0;
    s1_r  = v1_r ? (right_source_r ? $signed(rd_r_r) : $signed(rd_l_r)) : 16'sd0;
    f_inv = 25'(17'(gsve_pkg::Q16_ONE) - {1'b0, f_r});
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    live_nxt       = live_r;
    hop_count_nxt  = hop_count_r;
    pp_nxt         = pp_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    g_nxt          = g_r;
    slot_nxt       = slot_r;
    k_nxt          = k_r;
    prime_mode_nxt = prime_mode_r;
    have_nxt       = have_r;
    oldest_nxt     = oldest_r;
    off_nxt        = off_r;
    spawn_pos_nxt  = spawn_pos_r;
    spawn_age_nxt  = spawn_age_r;
    target_nxt     = target_r;
    speed_nxt      = speed_r;
    level_nxt      = level_r;
    dcnt_nxt       = dcnt_r;
    rem_nxt        = rem_r;
    num_nxt        = num_r;
    q_nxt          = q_r;
    i1_addr_nxt    = i1_addr_r;
    v0_nxt         = v0_r;
    v1_nxt         = v1_r;
    f_nxt          = f_r;
    s0_l_nxt       = s0_l_r;
    s0_r_nxt       = s0_r_r;
    w_nxt          = w_r;
    lin_l_nxt      = lin_l_r;
    lin_r_nxt      = lin_r_r;
    acc_l_nxt      = acc_l_r;
    acc_r_nxt      = acc_r_r;
    res_l_nxt      = res_l_r;
    res_r_nxt      = res_r_r;
    mul_a          = '0;
    mul_b          = '0;
    gsp_we         = 1'b0;
    gup_we         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      gsve_pkg::ST_IDLE: begin
        if (in_fire && (in_data.op == gsve_pkg::OP_RENDER)) begin
          target_nxt = in_data.target_pos;
          speed_nxt  = in_data.speed;
          level_nxt  = in_data.level;
          acc_l_nxt  = '0;
          acc_r_nxt  = '0;
          g_nxt      = '0;
          have_nxt   = 1'b0;
          state_nxt  = gsve_pkg::ST_G_CHK;
          pp_nxt     = pp_r | in_data.prime;
          if (in_data.active) begin
            if (pp_r || in_data.prime) begin
              pp_nxt         = 1'b0;
              hop_count_nxt  = hop_w;
              prime_mode_nxt = 1'b1;
              k_nxt          = 2'd3;
              off_nxt        = hop3_w;
              state_nxt      = gsve_pkg::ST_SP_MUL;
            end else if (hop_count_r == '0) begin
              hop_count_nxt  = hop_w - LW'(1);
              prime_mode_nxt = 1'b0;
              spawn_pos_nxt  = {8'b0, in_data.target_pos};
              spawn_age_nxt  = '0;
              state_nxt      = gsve_pkg::ST_SP_SCAN;
            end else begin
              hop_count_nxt = hop_count_r - LW'(1);
            end
          end
        end
      end
      gsve_pkg::ST_SP_MUL: begin
        mul_a     = MA'(off_r);
        mul_b     = 25'(speed_r);
        state_nxt = gsve_pkg::ST_SP_POS;
      end
      gsve_pkg::ST_SP_POS: begin
        spawn_pos_nxt = {8'b0, target_r} + p_r[39:0];
        spawn_age_nxt = off_r;
        g_nxt         = '0;
        have_nxt      = 1'b0;
        state_nxt     = gsve_pkg::ST_SP_SCAN;
      end
      gsve_pkg::ST_SP_SCAN: begin
        g_nxt = g_r + GIW'(1);
        if (!live_r[g_r]) begin
          slot_nxt  = g_r;
          state_nxt = gsve_pkg::ST_SP_WR;
        end else begin
          if (!have_r || (cur_age > oldest_r)) begin
            slot_nxt   = g_r;
            oldest_nxt = cur_age;
            have_nxt   = 1'b1;
          end
          if (g_r == G_LAST) begin
            state_nxt = gsve_pkg::ST_SP_WR;
          end
        end
      end
      gsve_pkg::ST_SP_WR: begin
        gsp_we           = 1'b1;
        live_nxt[slot_r] = 1'b1;
        g_nxt            = '0;
        have_nxt         = 1'b0;
        if (prime_mode_r && (k_r != 2'd0)) begin
          k_nxt     = k_r - 2'd1;
          off_nxt   = off_r - hop_w;
          state_nxt = gsve_pkg::ST_SP_MUL;
        end else begin
          state_nxt = gsve_pkg::ST_G_CHK;
        end
      end
      gsve_pkg::ST_G_CHK: begin
        if (!live_r[g_r]) begin
          g_nxt = g_r + GIW'(1);
          if (g_r == G_LAST) begin
            state_nxt = gsve_pkg::ST_F1;
          end
        end else begin
          dcnt_nxt    = '0;
          rem_nxt     = div_n[NW-1:11];
          num_nxt     = div_n[10:0];
          q_nxt       = '0;
          f_nxt       = cur_pos[15:0];
          i1_addr_nxt = AW'(i1_now);
          v0_nxt      = !i_now[23] && (32'(i_now) < STORE_DEPTH);
          v1_nxt      = !i1_now[24] && (32'(i1_now) < STORE_DEPTH);
          state_nxt   = gsve_pkg::ST_G_RD1;
        end
      end
      gsve_pkg::ST_G_RD1: begin
        s0_l_nxt  = v0_r ? $signed(rd_l_r) : 16'sd0;
        s0_r_nxt  = v0_r ? (right_source_r ? $signed(rd_r_r) : $signed(rd_l_r)) : 16'sd0;
        state_nxt = gsve_pkg::ST_G_DIV;
      end
      gsve_pkg::ST_G_DIV: begin
        if (!div_diff[LW+1]) begin
          rem_nxt = div_diff[LW-1:0];
          q_nxt   = {q_r[9:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[LW-2:0], num_r[10]};
          q_nxt   = {q_r[9:0], 1'b0};
        end
        num_nxt  = {num_r[9:0], 1'b0};
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'(DIV_LAST)) begin
          state_nxt = gsve_pkg::ST_M1;
        end
      end
      gsve_pkg::ST_M1: begin
        w_nxt     = win_w;
        mul_a     = MA'(s0_l_r);
        mul_b     = f_inv;
        state_nxt = gsve_pkg::ST_M2;
      end
      gsve_pkg::ST_M2: begin
        mul_a     = MA'(s1_l);
        mul_b     = 25'(f_r);
        lin_l_nxt = 33'(p_r);
        state_nxt = gsve_pkg::ST_M3;
      end
      gsve_pkg::ST_M3: begin
        mul_a     = MA'(s0_r_r);
        mul_b     = f_inv;
        lin_l_nxt = lin_l_r + 33'(p_r);
        state_nxt = gsve_pkg::ST_M4;
      end
      gsve_pkg::ST_M4: begin
        mul_a     = MA'(s1_r);
        mul_b     = 25'(f_r);
        lin_r_nxt = 33'(p_r);
        state_nxt = gsve_pkg::ST_M5;
      end
      gsve_pkg::ST_M5: begin
        mul_a     = MA'(lin_l_r);
        mul_b     = 25'(w_r);
        lin_r_nxt = lin_r_r + 33'(p_r);
        state_nxt = gsve_pkg::ST_M6;
      end
      gsve_pkg::ST_M6: begin
        mul_a     = MA'(lin_r_r);
        mul_b     = 25'(w_r);
        acc_l_nxt = acc_l_r + ACCW'(p_r);
        state_nxt = gsve_pkg::ST_M7;
      end
      gsve_pkg::ST_M7: begin
        acc_r_nxt = acc_r_r + ACCW'(p_r);
        gup_we    = 1'b1;
        if ((cur_age + LW'(1)) >= cur_span) begin
          live_nxt[g_r] = 1'b0;
        end
        g_nxt = g_r + GIW'(1);
        if (g_r == G_LAST) begin
          state_nxt = gsve_pkg::ST_F1;
        end else begin
          state_nxt = gsve_pkg::ST_G_CHK;
        end
      end
      gsve_pkg::ST_F1: begin
        mul_a     = MA'(acc_l_r >>> 16);
        mul_b     = 25'(level_r);
        state_nxt = gsve_pkg::ST_F2;
      end
      gsve_pkg::ST_F2: begin
        mul_a     = MA'(acc_r_r >>> 16);
        mul_b     = 25'(level_r);
        res_l_nxt = sat20(p_r);
        state_nxt = gsve_pkg::ST_F3;
      end
      gsve_pkg::ST_F3: begin
        res_r_nxt = sat20(p_r);
        state_nxt = gsve_pkg::ST_DONE;
      end
      gsve_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_left  = res_l_r;
          out_data_nxt.out_right = res_r_r;
          state_nxt              = gsve_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gsve_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= gsve_pkg::ST_IDLE;
      live_r         <= '0;
      hop_count_r    <= '0;
      pp_r           <= 1'b0;
      out_valid_r    <= 1'b0;
      grain_length_r <= gsve_pkg::GRAIN_LENGTH_RST;
      right_source_r <= gsve_pkg::RIGHT_SOURCE_RST;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      hop_count_r <= hop_count_nxt;
      pp_r        <= pp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          gsve_pkg::CFG_GRAIN_LENGTH: grain_length_r <= cfg_wdata[13:0];
          gsve_pkg::CFG_RIGHT_SOURCE: right_source_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    g_r          <= g_nxt;
    slot_r       <= slot_nxt;
    k_r          <= k_nxt;
    prime_mode_r <= prime_mode_nxt;
    have_r       <= have_nxt;
    oldest_r     <= oldest_nxt;
    off_r        <= off_nxt;
    spawn_pos_r  <= spawn_pos_nxt;
    spawn_age_r  <= spawn_age_nxt;
    target_r     <= target_nxt;
    speed_r      <= speed_nxt;
    level_r      <= level_nxt;
    dcnt_r       <= dcnt_nxt;
    rem_r        <= rem_nxt;
    num_r        <= num_nxt;
    q_r          <= q_nxt;
    i1_addr_r    <= i1_addr_nxt;
    v0_r         <= v0_nxt;
    v1_r         <= v1_nxt;
    f_r          <= f_nxt;
    s0_l_r       <= s0_l_nxt;
    s0_r_r       <= s0_r_nxt;
    w_r          <= w_nxt;
    lin_l_r      <= lin_l_nxt;
    lin_r_r      <= lin_r_nxt;
    acc_l_r      <= acc_l_nxt;
    acc_r_r      <= acc_r_nxt;
    res_l_r      <= res_l_nxt;
    res_r_r      <= res_r_nxt;
    p_r          <= PW'(mul_a) * PW'(mul_b);
  end

  // grain store
  always_ff @(posedge clk) begin
    if (gsp_we) begin
      grain_pos_r[slot_r]  <= spawn_pos_r;
      grain_age_r[slot_r]  <= spawn_age_r;
      grain_span_r[slot_r] <= len_w;
    end
    if (gup_we) begin
      grain_pos_r[g_r] <= cur_pos + 40'(speed_r);
      grain_age_r[g_r] <= cur_age + LW'(1);
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      store_left_r[AW'(in_data.sample_addr)]  <= in_data.sample_left;
      store_right_r[AW'(in_data.sample_addr)] <= in_data.sample_right;
    end
    rd_l_r <= store_left_r[rd_addr];
    rd_r_r <= store_right_r[rd_addr];
  end

endmodule

FILE: hdl/gsve_checker.sv
`timescale 1ns / 1ps
module gsve_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input gsve_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input gsve_pkg::out_item_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // a render beat blocks the input once taken
  a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == gsve_pkg::OP_RENDER) |=> !in_ready)
    else $error("input taken during render");

  // a write beat leaves the input ready
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == gsve_pkg::OP_WRITE) |=> in_ready)
    else $error("write beat stalled input");

  // a new result only ends a render
  a_out_from_render: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without render");

endmodule

bind granular_scrub_voice_engine_unit gsve_checker u_gsve_checker (.*);
